### design/csd_pkg.sv
// Package for the CAN signal decoder: payload types, signal table and lookup functions.
package csd_pkg;

    // Command codes
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam int SIG_COUNT = 70;

    // Input item, one transfer on the command side
    typedef struct packed {
        logic        command;
        logic [28:0] frame_id;
        logic [63:0] payload;
        logic [3:0]  data_length;
        logic [6:0]  read_slot;
    } t_item;

    // Result item, one transfer on the result side
    typedef struct packed {
        logic [6:0]         slot;
        logic signed [31:0] value;
        logic               is_read_reply;
        logic               last;
    } t_result;

    // Signal descriptor
    typedef struct packed {
        logic [6:0] slot;
        logic [5:0] start;
        logic [5:0] len;
        logic       sgn;
    } t_sig;

    // Run of table entries that belong to one identifier
    typedef struct packed {
        logic [6:0] base;
        logic [4:0] count;
    } t_span;

    // Classified job passed from front to back
    typedef struct packed {
        logic        is_read;
        t_span       span;
        logic [63:0] payload;
        logic [6:0]  read_slot;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_READ
    } t_back_state;

    // Signal table, grouped by identifier in table order
    localparam t_sig SIG_TABLE [0:SIG_COUNT-1] = '{
        // legacy single-byte values
        '{7'd0, 6'd0, 6'd8, 1'b0}, '{7'd1, 6'd0, 6'd8, 1'b0},
        '{7'd2, 6'd0, 6'd8, 1'b0}, '{7'd3, 6'd0, 6'd8, 1'b0},
        // id 6
        '{7'd10, 6'd0, 6'd16, 1'b0}, '{7'd11, 6'd16, 6'd16, 1'b0},
        '{7'd12, 6'd32, 6'd16, 1'b0},
        // id 1538
        '{7'd13, 6'd8, 6'd8, 1'b0}, '{7'd14, 6'd0, 6'd1, 1'b0},
        '{7'd15, 6'd1, 6'd1, 1'b0}, '{7'd16, 6'd2, 6'd1, 1'b0},
        '{7'd17, 6'd3, 6'd1, 1'b0}, '{7'd18, 6'd4, 6'd1, 1'b0},
        '{7'd19, 6'd5, 6'd1, 1'b0},
        // id 84
        '{7'd20, 6'd0, 6'd8, 1'b1}, '{7'd21, 6'd8, 6'd8, 1'b1},
        '{7'd22, 6'd16, 6'd8, 1'b0}, '{7'd23, 6'd32, 6'd16, 1'b0},
        '{7'd24, 6'd48, 6'd16, 1'b0},
        // id 86
        '{7'd25, 6'd0, 6'd8, 1'b0}, '{7'd26, 6'd8, 6'd8, 1'b0},
        // id 82
        '{7'd27, 6'd16, 6'd16, 1'b1}, '{7'd28, 6'd32, 6'd16, 1'b1},
        '{7'd29, 6'd48, 6'd16, 1'b1}, '{7'd30, 6'd0, 6'd16, 1'b1},
        // id 81
        '{7'd31, 6'd48, 6'd16, 1'b1}, '{7'd32, 6'd0, 6'd8, 1'b0},
        '{7'd33, 6'd8, 6'd8, 1'b0}, '{7'd34, 6'd16, 6'd16, 1'b1},
        '{7'd35, 6'd32, 6'd16, 1'b1},
        // id 3
        '{7'd36, 6'd22, 6'd1, 1'b0}, '{7'd37, 6'd21, 6'd1, 1'b0},
        '{7'd38, 6'd20, 6'd1, 1'b0}, '{7'd39, 6'd19, 6'd1, 1'b0},
        '{7'd40, 6'd18, 6'd1, 1'b0}, '{7'd41, 6'd17, 6'd1, 1'b0},
        '{7'd42, 6'd16, 6'd1, 1'b0}, '{7'd43, 6'd11, 6'd1, 1'b0},
        '{7'd44, 6'd10, 6'd1, 1'b0}, '{7'd45, 6'd9, 6'd1, 1'b0},
        '{7'd46, 6'd8, 6'd1, 1'b0}, '{7'd47, 6'd0, 6'd1, 1'b0},
        '{7'd48, 6'd4, 6'd1, 1'b0}, '{7'd49, 6'd3, 6'd1, 1'b0},
        '{7'd50, 6'd2, 6'd1, 1'b0}, '{7'd51, 6'd1, 6'd1, 1'b0},
        '{7'd52, 6'd5, 6'd1, 1'b0},
        // id 9
        '{7'd53, 6'd4, 6'd1, 1'b0}, '{7'd54, 6'd3, 6'd1, 1'b0},
        '{7'd55, 6'd2, 6'd1, 1'b0}, '{7'd56, 6'd1, 6'd1, 1'b0},
        '{7'd57, 6'd0, 6'd1, 1'b0},
        // id 4
        '{7'd58, 6'd32, 6'd32, 1'b0}, '{7'd59, 6'd16, 6'd16, 1'b0},
        '{7'd60, 6'd0, 6'd16, 1'b0},
        // id 0x18FF50E6
        '{7'd61, 6'd0, 6'd16, 1'b0},
        // id 0x1806E5F4
        '{7'd62, 6'd0, 6'd8, 1'b0}, '{7'd63, 6'd16, 6'd8, 1'b0},
        '{7'd64, 6'd32, 6'd1, 1'b0}, '{7'd65, 6'd8, 6'd8, 1'b0},
        '{7'd66, 6'd24, 6'd8, 1'b0},
        // id 0x18FF50E5
        '{7'd67, 6'd32, 6'd1, 1'b0}, '{7'd68, 6'd33, 6'd1, 1'b0},
        '{7'd69, 6'd34, 6'd1, 1'b0}, '{7'd70, 6'd35, 6'd1, 1'b0},
        '{7'd71, 6'd36, 6'd1, 1'b0}, '{7'd72, 6'd16, 6'd8, 1'b0},
        '{7'd73, 6'd24, 6'd8, 1'b0}, '{7'd74, 6'd0, 6'd8, 1'b0},
        '{7'd75, 6'd8, 6'd8, 1'b0}
    };

    // Identifier to table run; unknown identifiers give an empty run
    function automatic t_span id_lookup(input logic [28:0] id);
        t_span s;
        s = '{base: 7'd0, count: 5'd0};
        unique case (id)
            29'h417:      s = '{base: 7'd0,  count: 5'd1};
            29'h427:      s = '{base: 7'd1,  count: 5'd1};
            29'h437:      s = '{base: 7'd2,  count: 5'd1};
            29'h457:      s = '{base: 7'd3,  count: 5'd1};
            29'd6:        s = '{base: 7'd4,  count: 5'd3};
            29'd1538:     s = '{base: 7'd7,  count: 5'd7};
            29'd84:       s = '{base: 7'd14, count: 5'd5};
            29'd86:       s = '{base: 7'd19, count: 5'd2};
            29'd82:       s = '{base: 7'd21, count: 5'd4};
            29'd81:       s = '{base: 7'd25, count: 5'd5};
            29'd3:        s = '{base: 7'd30, count: 5'd17};
            29'd9:        s = '{base: 7'd47, count: 5'd5};
            29'd4:        s = '{base: 7'd52, count: 5'd3};
            29'h18FF50E6: s = '{base: 7'd55, count: 5'd1};
            29'h1806E5F4: s = '{base: 7'd56, count: 5'd5};
            29'h18FF50E5: s = '{base: 7'd61, count: 5'd9};
            default:      s = '{base: 7'd0,  count: 5'd0};
        endcase
        return s;
    endfunction

    // Cut one signal from the payload, sign-extending where marked
    function automatic logic [31:0] cut_signal(input logic [63:0] word, input t_sig d);
        logic [63:0] shifted;
        logic [63:0] mask;
        logic [31:0] raw;
        logic [31:0] sb;
        shifted = word >> d.start;
        mask    = (64'd1 << d.len) - 64'd1;
        raw     = shifted[31:0] & mask[31:0];
        if (d.sgn && (d.len > 6'd1) && (d.len < 6'd32)) begin
            sb  = 32'd1 << (d.len - 6'd1);
            raw = (raw ^ sb) - sb;
        end
        return raw;
    endfunction

endpackage

### design/csd_front.sv
// Front end: takes commands, looks up the identifier and masks missing payload bytes.
module csd_front import csd_pkg::*; (
    input  logic  i_start,
    input  t_item i_item,
    input  logic  i_full,
    output logic  o_busy,
    output logic  o_push,
    output t_job  o_job
);

    logic       w_accept;
    logic [3:0] w_dlc;
    t_span      w_span;

    assign o_busy   = i_full;
    assign w_accept = i_start && !i_full;
    assign w_span   = id_lookup(i_item.frame_id);

    // clamp DLC to eight bytes
    assign w_dlc = (i_item.data_length > 4'd8) ? 4'd8 : i_item.data_length;

    // bytes at or beyond the DLC read as zero
    always_comb begin
        o_job.is_read   = (i_item.command == CMD_READ);
        o_job.span      = w_span;
        o_job.read_slot = i_item.read_slot;
        for (int b = 0; b < 8; b++) begin
            o_job.payload[b*8 +: 8] = (4'(b) < w_dlc) ? i_item.payload[b*8 +: 8] : 8'd0;
        end
    end

    // unknown identifiers are dropped here and never queued
    assign o_push = w_accept && ((i_item.command == CMD_READ) || (w_span.count != 5'd0));

endmodule

### design/csd_queue.sv
// Two-entry job queue between the front end and the back end.
module csd_queue import csd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_not_empty
);

    localparam int DEPTH = 2;

    t_job       r_slots [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job       = r_slots[r_rd_ptr];
    assign o_full      = (r_count == 2'(DEPTH));
    assign o_not_empty = (r_count != 2'd0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wr_ptr] <= i_job;
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty) else $error("queue popped while empty");

endmodule

### design/csd_back.sv
// Back end: walks the signal table for a job, updates the signal store and emits results.
module csd_back import csd_pkg::*; #(
    parameter int NUM_SLOTS = 76
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  logic    i_not_empty,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic [6:0]  r_idx, n_idx;
    logic [4:0]  r_left, n_left;
    logic        r_valid, n_valid;
    t_result     r_res, n_res;

    // signal store with per-entry valid bits
    logic [31:0]          r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    logic [31:0]          r_rd_data;
    logic                 r_rd_hit;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [31:0]       w_wdata;
    logic [SLOT_W-1:0] w_raddr;
    logic              w_in_range;
    t_sig              w_sig;

    assign o_valid  = r_valid;
    assign o_result = r_res;

    assign w_raddr    = i_job.read_slot[SLOT_W-1:0];
    assign w_in_range = ({1'b0, i_job.read_slot} < 8'(NUM_SLOTS));
    assign w_sig      = SIG_TABLE[r_idx];

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_left  <= 5'd0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_left  <= n_left;
        end
        r_job <= n_job;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    // next state, table walk and store write
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_idx   = r_idx;
        n_left  = r_left;
        n_valid = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = w_sig.slot[SLOT_W-1:0];
        w_wdata = cut_signal(r_job.payload, w_sig);
        unique case (r_state)
            ST_IDLE: begin
                if (i_not_empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_job;
                    n_idx  = i_job.span.base;
                    n_left = i_job.span.count;
                    n_state = i_job.is_read ? ST_READ : ST_RUN;
                end
            end
            ST_RUN: begin
                w_we    = 1'b1;
                n_valid = 1'b1;
                n_res.slot          = w_sig.slot;
                n_res.value         = w_wdata;
                n_res.is_read_reply = 1'b0;
                n_res.last          = (r_left == 5'd1);
                n_idx   = r_idx + 7'd1;
                n_left  = r_left - 5'd1;
                if (r_left == 5'd1) n_state = ST_IDLE;
            end
            ST_READ: begin
                n_valid = 1'b1;
                n_res.slot          = r_job.read_slot;
                n_res.value         = r_rd_hit ? r_rd_data : 32'd0;
                n_res.is_read_reply = 1'b1;
                n_res.last          = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // store write port and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    // store read port, registered; unwritten or out-of-range slots read as zero
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[w_raddr];
            r_rd_hit  <= w_in_range && r_vld[w_raddr];
        end
    end

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.is_read_reply |-> r_res.last) else $error("read reply not last");
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_left != 5'd0) else $error("table walk with nothing left");
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != ST_IDLE) else $error("popped job not started");
    a_upd_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_res.is_read_reply |-> ({1'b0, r_res.slot} < 8'(NUM_SLOTS)))
        else $error("update slot outside store");

endmodule

### design/can_signal_decoder_unit.sv
// Top level of the CAN signal decoder: front end, job queue and back end.
//
//  channel   | handshake          | payload          | direction
//  ----------+--------------------+------------------+----------
//  command   | start / busy       | i_item (t_item)  | in
//  result    | o_valid strobe     | o_result         | out
//
// A read's reply passes the job queue, the back end's registered store read port and
// its result register; a frame's first update passes the job queue, the back end's
// state and its result register, then one update per cycle follows for each signal of
// its identifier (up to 17). The back end takes a job from the queue only when idle,
// once it is through with the last one. Unknown identifiers are dropped in the front
// end and cause no result. busy is high while the two-entry job queue is full; results
// cannot be stalled. Synchronous reset clears control state and all store valid bits.
module can_signal_decoder_unit import csd_pkg::*; #(
    parameter int NUM_SLOTS = 76
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_not_empty;
    t_job w_front_job;
    t_job w_head_job;

    csd_front u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_job   (w_front_job)
    );

    csd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_front_job),
        .i_pop       (w_pop),
        .o_job       (w_head_job),
        .o_full      (w_full),
        .o_not_empty (w_not_empty)
    );

    csd_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_not_empty (w_not_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule
